[src/assert_macros.svh]
// Concurrent assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AAER_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define AAER_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition");
`else
`define AAER_ASSERT(lbl, clk, rstn, prop)
`define AAER_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

[src/aaer_pkg.sv]
package aaer_pkg;

  localparam int unsigned PCM_W       = 16;
  localparam int unsigned STEP_W      = 15;
  localparam int unsigned SCALE_W     = 10;
  localparam int unsigned NUM_SCALES  = 8;
  localparam int unsigned SCALE_IDX_W = 3;
  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned CODE_W      = 4;
  localparam int unsigned NUM_W       = 19;
  localparam int unsigned QUO_W       = 4;
  localparam int unsigned PROD_W      = STEP_W + SCALE_W;

  localparam int unsigned MIN_STEP_DEF = 127;
  localparam int unsigned MAX_STEP_DEF = 24576;

  localparam logic [SCALE_W-1:0] SCALE_RST [NUM_SCALES] = '{
    10'd230, 10'd230, 10'd230, 10'd230, 10'd307, 10'd409, 10'd512, 10'd614
  };

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } quant_rsp_t;

endpackage

[src/aaer_if.sv]
interface aaer_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [aaer_pkg::PCM_W-1:0]  pcm_in;
  logic                               restart;

  modport source (output valid, output pcm_in, output restart, input ready);
  modport sink (input valid, input pcm_in, input restart, output ready);
endinterface

interface aaer_out_if;
  logic                               valid;
  logic                               ready;
  logic        [aaer_pkg::CODE_W-1:0] code;
  logic signed [aaer_pkg::PCM_W-1:0]  pcm_out;

  modport source (output valid, output code, output pcm_out, input ready);
  modport sink (input valid, input code, input pcm_out, output ready);
endinterface

[src/aaer_cfg.sv]
module aaer_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             we_i,
  input  logic [aaer_pkg::CFG_IDX_W-1:0]   idx_i,
  input  logic [aaer_pkg::SCALE_W-1:0]     wdata_i,
  input  logic [aaer_pkg::SCALE_IDX_W-1:0] rd_idx_i,
  output logic [aaer_pkg::SCALE_W-1:0]     rd_data_o
);
  import aaer_pkg::*;

  logic [SCALE_W-1:0] scale_q [NUM_SCALES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RST;
    end else if (we_i && (idx_i < CFG_IDX_W'(NUM_SCALES))) begin
      scale_q[idx_i[SCALE_IDX_W-1:0]] <= wdata_i;
    end
  end

  assign rd_data_o = scale_q[rd_idx_i];

endmodule

[src/aaer_quant.sv]
module aaer_quant (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [aaer_pkg::NUM_W-1:0]   num_i,
  input  logic [aaer_pkg::STEP_W-1:0]  den_i,
  output aaer_pkg::quant_rsp_t         rsp_o
);
  import aaer_pkg::*;

  // compare-subtract per cycle; first pass checks for quotient >= 16
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [2:0]         k_q, k_d;
  logic [NUM_W-1:0]   rem_q, rem_d;
  logic [STEP_W-1:0]  den_q, den_d;
  logic [QUO_W-1:0]   quo_q, quo_d;
  logic [NUM_W:0]     trial;
  logic               ge;

  assign trial = {{(NUM_W + 1 - STEP_W){1'b0}}, den_q} << k_q;
  assign ge    = {1'b0, rem_q} >= trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    k_d    = k_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      k_d    = 3'd4;
      rem_d  = num_i;
      den_d  = den_i;
      quo_d  = '0;
    end else if (busy_q) begin
      if (k_q == 3'd4) begin
        if (ge) begin
          quo_d  = '1;
          busy_d = 1'b0;
          done_d = 1'b1;
        end else begin
          k_d = 3'd3;
        end
      end else begin
        if (ge) begin
          rem_d               = rem_q - trial[NUM_W-1:0];
          quo_d[k_q[1:0]]     = 1'b1;
        end
        if (k_q == 3'd0) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end else begin
          k_d = k_q - 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      k_q    <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

[src/adaptive_adpcm_encode_reconstruct_unit.sv]
// Flow: a setup step on the input beat, the quantizer compare/subtract passes,
// 2 passes through the shared step multiplier, then prediction and step update;
// the quantizer stops after its first pass when the quotient reaches 16.
// One sample in flight: input is ready only in idle; a result waits on output stall.
// The next sample is accepted while a finished result waits on the output.
// Reset (async, active low): prediction 0, step at the minimum, scales to defaults.
`include "assert_macros.svh"

module adaptive_adpcm_encode_reconstruct_unit #(
  parameter int unsigned MIN_STEP = aaer_pkg::MIN_STEP_DEF,
  parameter int unsigned MAX_STEP = aaer_pkg::MAX_STEP_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [aaer_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [aaer_pkg::SCALE_W-1:0]   cfg_wdata_i,
  aaer_in_if.sink                        in_i,
  aaer_out_if.source                     out_o
);
  import aaer_pkg::*;

  localparam logic [STEP_W-1:0] MIN_S = STEP_W'(MIN_STEP);
  localparam logic [STEP_W-1:0] MAX_S = STEP_W'(MAX_STEP);
  localparam logic [STEP_W-1:0] RST_S = (MIN_S > MAX_S) ? MAX_S : MIN_S;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIV  = 6'b000010,
    ST_AMT  = 6'b000100,
    ST_REC  = 6'b001000,
    ST_STP  = 6'b010000,
    ST_DONE = 6'b100000
  } state_e;

  state_e                    state_q, state_d;
  logic signed [PCM_W-1:0]   pred_q, pred_d;
  logic [STEP_W-1:0]         step_q, step_d;
  logic                      sign_q, sign_d;
  logic [2:0]                mag_q, mag_d;
  logic [PROD_W-1:0]         prod_q, prod_d;
  logic                      out_valid_q, out_valid_d;
  logic [CODE_W-1:0]         out_code_q, out_code_d;
  logic signed [PCM_W-1:0]   out_pcm_q, out_pcm_d;

  logic                      accept;
  logic                      done_go;
  logic [PCM_W-1:0]          pred_base;
  logic [STEP_W-1:0]         step_base;
  logic [PCM_W:0]            diff;
  logic [PCM_W:0]            diff_neg;
  logic [PCM_W-1:0]          mag;
  logic [NUM_W-1:0]          num;
  quant_rsp_t                qrsp;
  logic [2:0]                m_new;
  logic [QUO_W-1:0]          quo_m1;
  logic [SCALE_W-1:0]        scale_rd;
  logic [SCALE_W-1:0]        mul_b;
  logic [PROD_W-1:0]         mul_p;
  logic [PCM_W-1:0]          amount;
  logic [PCM_W+1:0]          rec;
  logic [PCM_W:0]            s_raw;
  logic [PCM_W:0]            s_lo;

  assign accept  = in_i.valid && in_i.ready;
  assign done_go = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);
  assign in_i.ready = (state_q == ST_IDLE);

  assign pred_base = in_i.restart ? '0 : pred_q;
  assign step_base = in_i.restart ? RST_S : step_q;
  assign diff      = {in_i.pcm_in[PCM_W-1], in_i.pcm_in} - {pred_base[PCM_W-1], pred_base};
  assign diff_neg  = '0 - diff;
  assign mag       = diff[PCM_W] ? diff_neg[PCM_W-1:0] : diff[PCM_W-1:0];
  assign num       = {mag, 3'b000};

  aaer_quant u_quant (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .num_i   (num),
    .den_i   (step_base),
    .rsp_o   (qrsp)
  );

  aaer_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (cfg_we_i),
    .idx_i     (cfg_idx_i),
    .wdata_i   (cfg_wdata_i),
    .rd_idx_i  (mag_q),
    .rd_data_o (scale_rd)
  );

  assign quo_m1 = qrsp.quo - QUO_W'(1);
  assign m_new  = (qrsp.quo == '0) ? 3'd0 : quo_m1[3:1];

  // shared multiplier: step*(2m+1) first, then step*scale[m]
  assign mul_b = (state_q == ST_AMT) ? {{(SCALE_W - 4){1'b0}}, mag_q, 1'b1} : scale_rd;
  assign mul_p = PROD_W'(step_q) * PROD_W'(mul_b);

  assign amount = prod_q[PCM_W+2:3];
  assign rec    = sign_q ? ({{2{pred_q[PCM_W-1]}}, pred_q} - {2'b00, amount})
                         : ({{2{pred_q[PCM_W-1]}}, pred_q} + {2'b00, amount});

  assign s_raw = prod_q[PROD_W-1:8];
  assign s_lo  = (s_raw < (PCM_W+1)'(MIN_S)) ? (PCM_W+1)'(MIN_S) : s_raw;

  always_comb begin
    state_d     = state_q;
    pred_d      = pred_q;
    step_d      = step_q;
    sign_d      = sign_q;
    mag_d       = mag_q;
    prod_d      = prod_q;
    out_valid_d = out_valid_q;
    out_code_d  = out_code_q;
    out_pcm_d   = out_pcm_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          pred_d  = pred_base;
          step_d  = step_base;
          sign_d  = diff[PCM_W];
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (qrsp.done) begin
          mag_d   = m_new;
          state_d = ST_AMT;
        end
      end
      ST_AMT: begin
        prod_d  = mul_p;
        state_d = ST_REC;
      end
      ST_REC: begin
        priority if (rec[PCM_W+1] && (rec[PCM_W:PCM_W-1] != 2'b11)) begin
          pred_d = {1'b1, {(PCM_W - 1){1'b0}}};
        end else if (!rec[PCM_W+1] && (rec[PCM_W:PCM_W-1] != 2'b00)) begin
          pred_d = {1'b0, {(PCM_W - 1){1'b1}}};
        end else begin
          pred_d = rec[PCM_W-1:0];
        end
        prod_d  = mul_p;
        state_d = ST_STP;
      end
      ST_STP: begin
        step_d  = (s_lo > (PCM_W+1)'(MAX_S)) ? MAX_S : s_lo[STEP_W-1:0];
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (done_go) begin
          out_valid_d = 1'b1;
          out_code_d  = {sign_q, mag_q};
          out_pcm_d   = pred_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pred_q      <= '0;
      step_q      <= RST_S;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pred_q      <= pred_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sign_q     <= sign_d;
    mag_q      <= mag_d;
    prod_q     <= prod_d;
    out_code_q <= out_code_d;
    out_pcm_q  <= out_pcm_d;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.code    = out_code_q;
  assign out_o.pcm_out = out_pcm_q;

  `AAER_ASSERT(a_step_range, clk_i, rst_ni, (step_q >= RST_S) && (step_q <= MAX_S))
  `AAER_ASSERT_NEVER(a_quant_done_state, clk_i, rst_ni, qrsp.done && (state_q != ST_DIV))
  `AAER_ASSERT(a_done_to_out, clk_i, rst_ni, done_go |=> (out_valid_q && (state_q == ST_IDLE)))

endmodule

[verif/tb.sv]
module tb;
  import aaer_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE_CODE0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = CFG_IDX_W'(NUM_SCALES);
  localparam int PCM_MIN = -32768;
  localparam int PCM_MAX = 32767;
  localparam int unsigned MAG_MAX = 7;
  localparam int unsigned QUANT_SHIFT = 3;
  localparam int unsigned SCALE_SHIFT = 8;
  localparam int SETTLE_CYC = 16;
  localparam int NUM_PHASES = 8;
  localparam int RANDOM_PER_PHASE = 250;
  localparam int DIR_N = 23;

  typedef struct packed {
    logic signed [PCM_W-1:0] pcm;
    logic                    restart;
  } sample_t;

  typedef struct packed {
    logic        [CODE_W-1:0] code;
    logic signed [PCM_W-1:0]  pcm;
  } coded_t;

  typedef enum int {SEG_NOISE, SEG_WALK, SEG_SWING, SEG_HOLD} seg_kind_e;
  typedef enum int {CFG_DEFAULT, CFG_RANDOM, CFG_ZERO, CFG_FULL, CFG_SPLIT} cfg_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [SCALE_W-1:0]   cfg_wdata_i;

  aaer_in_if  in_if ();
  aaer_out_if out_if ();

  adaptive_adpcm_encode_reconstruct_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always #5 clk_i = ~clk_i;

  sample_t pending_q[$];
  coded_t  coded_q[$];
  int      queued_cnt = 0;
  int      accepted_cnt = 0;
  int      err_cnt = 0;
  bit      steady = 1'b0;

  logic [SCALE_W-1:0] model_scale [NUM_SCALES];
  int                 model_pred;
  int unsigned        model_step;

  function automatic int unsigned clamp_step(input int unsigned s);
    int unsigned r;
    r = s;
    if (r < MIN_STEP_DEF) r = MIN_STEP_DEF;
    if (r > MAX_STEP_DEF) r = MAX_STEP_DEF;
    if (r == 0) r = 1;
    return r;
  endfunction

  function automatic coded_t encode_sample(input logic signed [PCM_W-1:0] pcm,
                                           input logic restart);
    int          diff;
    int          recon;
    int unsigned mag;
    int unsigned quo;
    int unsigned mcode;
    int unsigned amount;
    logic        neg;
    coded_t      res;
    if (restart) begin
      model_pred = 0;
      model_step = clamp_step(MIN_STEP_DEF);
    end
    diff = int'(pcm) - model_pred;
    neg = (diff < 0);
    mag = neg ? -diff : diff;
    quo = (mag << QUANT_SHIFT) / model_step;
    mcode = (quo == 0) ? 0 : (quo - 1) / 2;
    if (mcode > MAG_MAX) mcode = MAG_MAX;
    amount = (model_step * (2 * mcode + 1)) >> QUANT_SHIFT;
    recon = neg ? model_pred - int'(amount) : model_pred + int'(amount);
    if (recon < PCM_MIN) recon = PCM_MIN;
    if (recon > PCM_MAX) recon = PCM_MAX;
    model_pred = recon;
    model_step = clamp_step((model_step * model_scale[mcode[SCALE_IDX_W-1:0]]) >> SCALE_SHIFT);
    res.code = {neg, mcode[2:0]};
    res.pcm = recon[PCM_W-1:0];
    return res;
  endfunction

  // sender: bursts with random gaps
  sample_t drv_item;
  int      burst_left = 0;
  int      gap_left = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        coded_q.push_back(encode_sample(in_if.pcm_in, in_if.restart));
        accepted_cnt++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0 && !steady) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          drv_item = pending_q.pop_front();
          in_if.valid <= 1'b1;
          in_if.pcm_in <= drv_item.pcm;
          in_if.restart <= drv_item.restart;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: rotating 32-bit stall pattern, reloaded each time it wraps
  logic [31:0] rdy_pat = '1;
  logic [4:0]  pat_pos = '0;
  coded_t      want;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (coded_q.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual code %h pcm %0d",
                   $time, out_if.code, out_if.pcm_out);
          err_cnt++;
        end else begin
          want = coded_q.pop_front();
          if (want.code !== out_if.code) begin
            $display("%0t: code mismatch, expected %h actual %h",
                     $time, want.code, out_if.code);
            err_cnt++;
          end
          if (want.pcm !== out_if.pcm_out) begin
            $display("%0t: pcm_out mismatch, expected %0d actual %0d",
                     $time, want.pcm, out_if.pcm_out);
            err_cnt++;
          end
        end
      end
      if (steady) begin
        out_if.ready <= 1'b1;
      end else begin
        if (pat_pos == 0) begin
          case ($urandom_range(0, 4))
            0: rdy_pat = '1;
            1: rdy_pat = $urandom | $urandom;
            2: rdy_pat = $urandom;
            3: rdy_pat = $urandom & $urandom;
            default: rdy_pat = '0;
          endcase
        end
        out_if.ready <= rdy_pat[pat_pos];
        pat_pos = pat_pos + 1'b1;
      end
    end
  end

  task automatic push_sample(input int pcm, input bit restart);
    sample_t s;
    s.pcm = pcm[PCM_W-1:0];
    s.restart = restart;
    pending_q.push_back(s);
    queued_cnt++;
  endtask

  task automatic queue_segment(input int n);
    seg_kind_e kind;
    int        level;
    int        amp;
    int        k;
    kind = seg_kind_e'($urandom_range(0, 3));
    level = int'($urandom_range(0, 65535)) + PCM_MIN;
    amp = 1 << $urandom_range(0, 15);
    for (k = 0; k < n; k++) begin
      case (kind)
        SEG_NOISE: level = int'($urandom_range(0, 65535)) + PCM_MIN;
        SEG_WALK: begin
          level = level + int'($urandom_range(0, 2 * amp)) - amp;
          if (level < PCM_MIN) level = PCM_MIN;
          if (level > PCM_MAX) level = PCM_MAX;
        end
        SEG_SWING: level = $urandom_range(0, 1) ? PCM_MAX : PCM_MIN;
        default: ;
      endcase
      push_sample(level, (k == 0 && $urandom_range(0, 3) != 0) ||
                         $urandom_range(0, 99) == 0);
    end
  endtask

  task automatic queue_directed();
    int dir_pcm [DIR_N] = '{0, 0, 1, -1, PCM_MAX, PCM_MAX, PCM_MAX, PCM_MAX, PCM_MAX,
                            PCM_MAX, PCM_MIN, PCM_MIN, PCM_MIN, PCM_MIN, PCM_MIN,
                            PCM_MIN, PCM_MAX, 0, 21845, -21846, 5, 4, 3};
    bit dir_rst [DIR_N] = '{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                            1, 1, 0, 0, 0, 1, 0, 0};
    int k;
    for (k = 0; k < DIR_N; k++) push_sample(dir_pcm[k[4:0]], dir_rst[k[4:0]]);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SCALE_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    if (idx < NUM_SCALES) model_scale[idx[SCALE_IDX_W-1:0]] = val;
  endtask

  function automatic logic [SCALE_W-1:0] scale_for(input cfg_mode_e mode, input int i);
    case (mode)
      CFG_DEFAULT: return SCALE_RST[i[SCALE_IDX_W-1:0]];
      CFG_ZERO:    return '0;
      CFG_FULL:    return '1;
      CFG_SPLIT:   return $urandom_range(0, 1) ? '1 : SCALE_W'($urandom_range(0, 300));
      default:     return SCALE_W'($urandom_range(0, 1023));
    endcase
  endfunction

  task automatic wait_idle();
    while (accepted_cnt != queued_cnt || coded_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  initial begin
    cfg_mode_e plan [NUM_PHASES] = '{CFG_DEFAULT, CFG_RANDOM, CFG_ZERO, CFG_FULL,
                                     CFG_RANDOM, CFG_SPLIT, CFG_DEFAULT, CFG_RANDOM};
    int ph;
    int i;
    int start_cnt;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    in_if.valid = 1'b0;
    in_if.pcm_in = '0;
    in_if.restart = 1'b0;
    out_if.ready = 1'b0;
    for (i = 0; i < NUM_SCALES; i++) begin
      model_scale[i[SCALE_IDX_W-1:0]] = SCALE_RST[i[SCALE_IDX_W-1:0]];
    end
    model_pred = 0;
    model_step = clamp_step(MIN_STEP_DEF);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      steady = (ph == 4);
      for (i = 0; i < NUM_SCALES; i++) begin
        write_reg(REG_SCALE_CODE0 + CFG_IDX_W'(i), scale_for(plan[ph], i));
      end
      // out-of-range index must be ignored
      write_reg(REG_UNUSED_FIRST + CFG_IDX_W'($urandom_range(0, NUM_SCALES - 1)),
                SCALE_W'($urandom_range(0, 1023)));
      @(posedge clk_i);
      cfg_we_i <= 1'b0;
      if (ph == 0 || plan[ph] == CFG_ZERO || plan[ph] == CFG_FULL) queue_directed();
      start_cnt = queued_cnt;
      while (queued_cnt - start_cnt < RANDOM_PER_PHASE) queue_segment($urandom_range(4, 60));
    end
    wait_idle();
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

[adaptive_adpcm_encode_reconstruct_unit.f]
+incdir+src
src/aaer_pkg.sv
src/aaer_if.sv
src/aaer_cfg.sv
src/aaer_quant.sv
src/adaptive_adpcm_encode_reconstruct_unit.sv
verif/tb.sv
